// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RC PWM decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Widths, register map, reset values and shared types of the RC PWM decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpwm_pkg;

  localparam int PULSE_W    = 15;
  localparam int TIME_W     = 32;
  localparam int US_W       = 12;
  localparam int ANGLE_W    = 15;
  localparam int RATE_W     = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int SET_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Divider datapath: |diff| times full scale, then a 16-bit rounded quotient.
  localparam int MAG_W  = 12;
  localparam int FULL_W = 16;
  localparam int PROD_W = MAG_W + FULL_W;
  localparam int QUO_W  = 16;
  localparam int REM_W  = MAG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

  localparam logic [US_W-1:0]      CENTER_RST  = 12'd1500;
  localparam logic [US_W-1:0]      MIN_RST     = 12'd1000;
  localparam logic [US_W-1:0]      MAX_RST     = 12'd2000;
  localparam logic [ANGLE_W-1:0]   ANGLE_RST   = 15'd7680;
  localparam logic [RATE_W-1:0]    YAW_RST     = 16'd46080;
  localparam logic [US_W-1:0]      MODE_RST    = 12'd1700;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;

  localparam logic [PULSE_W-1:0] PULSE_LO_US   = 15'd900;
  localparam logic [PULSE_W-1:0] PULSE_HI_US   = 15'd2100;
  localparam logic [SET_W-1:0]   THROTTLE_FULL = 16'h8000;

  typedef struct packed {
    logic [US_W-1:0]      center_pulse_us;
    logic [US_W-1:0]      min_pulse_us;
    logic [US_W-1:0]      max_pulse_us;
    logic [ANGLE_W-1:0]   max_angle_q8;
    logic [RATE_W-1:0]    max_yaw_rate_q8;
    logic [US_W-1:0]      mode_threshold_us;
    logic [TIMEOUT_W-1:0] failsafe_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [PROD_W-1:0] num;
    logic [MAG_W-1:0]  den;
  } div_load_t;

  typedef struct packed {
    logic             busy;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_status_t;

endpackage

`default_nettype wire

// ===== sv/rcpwm_poll_if.sv =====
// ----------------------------------------------------------------------------
// rcpwm_poll_if
// Request channel carrying five measured pulse widths and the millisecond time.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpwm_poll_if;
  logic                         valid;
  logic                         ready;
  logic [rcpwm_pkg::PULSE_W-1:0] roll_pulse_us;
  logic [rcpwm_pkg::PULSE_W-1:0] pitch_pulse_us;
  logic [rcpwm_pkg::PULSE_W-1:0] throttle_pulse_us;
  logic [rcpwm_pkg::PULSE_W-1:0] yaw_pulse_us;
  logic [rcpwm_pkg::PULSE_W-1:0] mode_pulse_us;
  logic [rcpwm_pkg::TIME_W-1:0]  now_ms;

  modport source (
    output valid, roll_pulse_us, pitch_pulse_us, throttle_pulse_us,
    output yaw_pulse_us, mode_pulse_us, now_ms,
    input  ready
  );

  modport sink (
    input  valid, roll_pulse_us, pitch_pulse_us, throttle_pulse_us,
    input  yaw_pulse_us, mode_pulse_us, now_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rcpwm_result_if.sv =====
// ----------------------------------------------------------------------------
// rcpwm_result_if
// Result channel carrying the setpoints, mode and frame status.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpwm_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [rcpwm_pkg::SET_W-1:0] roll_set_q8;
  logic signed [rcpwm_pkg::SET_W-1:0] pitch_set_q8;
  logic        [rcpwm_pkg::SET_W-1:0] throttle_q15;
  logic signed [rcpwm_pkg::SET_W-1:0] yaw_rate_set_q8;
  logic                              land_mode;
  logic                              frame_valid;
  logic                              failsafe;

  modport source (
    output valid, roll_set_q8, pitch_set_q8, throttle_q15, yaw_rate_set_q8,
    output land_mode, frame_valid, failsafe,
    input  ready
  );

  modport sink (
    input  valid, roll_set_q8, pitch_set_q8, throttle_q15, yaw_rate_set_q8,
    input  land_mode, frame_valid, failsafe,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rcpwm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rcpwm_cfg_regs
// Write-only configuration registers of the RC PWM decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [rcpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output rcpwm_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_pulse_us     <= rcpwm_pkg::CENTER_RST;
      cfg.min_pulse_us        <= rcpwm_pkg::MIN_RST;
      cfg.max_pulse_us        <= rcpwm_pkg::MAX_RST;
      cfg.max_angle_q8        <= rcpwm_pkg::ANGLE_RST;
      cfg.max_yaw_rate_q8     <= rcpwm_pkg::YAW_RST;
      cfg.mode_threshold_us   <= rcpwm_pkg::MODE_RST;
      cfg.failsafe_timeout_ms <= rcpwm_pkg::TIMEOUT_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        rcpwm_pkg::REG_CENTER:  cfg.center_pulse_us <= cfg_data[rcpwm_pkg::US_W-1:0];
        rcpwm_pkg::REG_MIN:     cfg.min_pulse_us    <= cfg_data[rcpwm_pkg::US_W-1:0];
        rcpwm_pkg::REG_MAX:     cfg.max_pulse_us    <= cfg_data[rcpwm_pkg::US_W-1:0];
        rcpwm_pkg::REG_ANGLE:   cfg.max_angle_q8    <= cfg_data[rcpwm_pkg::ANGLE_W-1:0];
        rcpwm_pkg::REG_YAW:     cfg.max_yaw_rate_q8 <= cfg_data[rcpwm_pkg::RATE_W-1:0];
        rcpwm_pkg::REG_MODE:    cfg.mode_threshold_us <= cfg_data[rcpwm_pkg::US_W-1:0];
        rcpwm_pkg::REG_TIMEOUT: begin
          cfg.failsafe_timeout_ms <= cfg_data[rcpwm_pkg::TIMEOUT_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rcpwm_div_lane.sv =====
// ----------------------------------------------------------------------------
// rcpwm_div_lane
// Bit-serial restoring divider giving round(num / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcpwm_div_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  rcpwm_pkg::div_load_t   ld,
  output rcpwm_pkg::div_status_t st
);

  localparam int QUO_W = rcpwm_pkg::QUO_W;
  localparam int REM_W = rcpwm_pkg::REM_W;
  localparam int N_W   = rcpwm_pkg::PROD_W + 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic             busy;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] d2;
  logic [QUO_W-1:0] nsh;
  logic [QUO_W-1:0] quo;

  // Rounding to nearest: (2n + d) / (2d), with the low quotient bits shifted
  // in one at a time. A quotient of 2^16 or more only needs to be flagged.
  logic [N_W-1:0]   n_full;
  logic [REM_W-1:0] n_hi;
  logic [REM_W-1:0] d2_ld;
  logic             ovf_ld;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   sub;
  logic             fits;

  assign n_full = {ld.num, 1'b0} + N_W'(ld.den);
  assign n_hi   = n_full[N_W-1 -: REM_W];
  assign d2_ld  = {ld.den, 1'b0};
  assign ovf_ld = (n_hi >= d2_ld);
  assign trial  = {rem, nsh[QUO_W-1]};
  assign sub    = trial - {1'b0, d2};
  assign fits   = (trial >= {1'b0, d2});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ld.load) begin
      ovf  <= ovf_ld;
      rem  <= n_hi;
      nsh  <= n_full[QUO_W-1:0];
      quo  <= '0;
      d2   <= d2_ld;
      cnt  <= CNT_W'(QUO_W - 1);
      busy <= !ovf_ld;
    end else if (busy) begin
      rem <= fits ? sub[REM_W-1:0] : trial[REM_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
      nsh <= {nsh[QUO_W-2:0], 1'b0};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign st = '{busy: busy, ovf: ovf, quo: quo};

  `ASSERT_IMPLIES(a_no_load_busy, clk, rst, ld.load, !busy, "load while busy")
  `ASSERT_IMPLIES(a_rem_below_div, clk, rst, busy, rem < d2, "remainder not below divisor")
  `ASSERT_NEXT(a_load_starts, clk, rst, ld.load, busy || ovf, "load did not start")

endmodule

`default_nettype wire

// ===== sv/rc_pwm_channel_decoder_failsafe.sv =====
// ----------------------------------------------------------------------------
// rc_pwm_channel_decoder_failsafe
// A valid poll passes the range check, the products, the 16-step bit-serial
// dividers and the mapping step before its result is loaded; a poll that fails
// the range check goes from the check straight to loading its result.
// One poll at a time: the next is taken the cycle after the result is loaded;
// a result still waiting at the output holds the next one in its last step.
// Synchronous reset restores the register defaults, clears the held setpoints
// and raises failsafe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rc_pwm_channel_decoder_failsafe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [rcpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_data,
  rcpwm_poll_if.sink                       poll,
  rcpwm_result_if.source                   result
);

  localparam int NUM_CH  = 4;
  localparam int IDX_W   = $clog2(NUM_CH + 1);
  localparam int CH_W    = $clog2(NUM_CH);
  localparam int US_W    = rcpwm_pkg::US_W;
  localparam int MAG_W   = rcpwm_pkg::MAG_W;
  localparam int FULL_W  = rcpwm_pkg::FULL_W;
  localparam int PROD_W  = rcpwm_pkg::PROD_W;
  localparam int SET_W   = rcpwm_pkg::SET_W;
  localparam int QUO_W   = rcpwm_pkg::QUO_W;
  localparam int PULSE_W = rcpwm_pkg::PULSE_W;
  localparam int TIME_W  = rcpwm_pkg::TIME_W;
  localparam int DIFF_W  = US_W + 1;

  localparam logic [CH_W-1:0] CH_ROLL  = 2'd0;
  localparam logic [CH_W-1:0] CH_PITCH = 2'd1;
  localparam logic [CH_W-1:0] CH_THR   = 2'd2;
  localparam logic [CH_W-1:0] CH_YAW   = 2'd3;

  localparam logic [SET_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [SET_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MUL, S_DIV, S_MAP, S_DONE} state_t;

  rcpwm_pkg::cfg_t        cfg;
  rcpwm_pkg::div_load_t   lane_ld [NUM_CH];
  rcpwm_pkg::div_status_t lane_st [NUM_CH];

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] prod;

  logic [PULSE_W-1:0] p_roll, p_pitch, p_thr, p_yaw, p_mode;
  logic [TIME_W-1:0]  now_reg;

  // Per-channel operands captured at the range check.
  logic [MAG_W-1:0]  ch_mag   [NUM_CH];
  logic [FULL_W-1:0] ch_full  [NUM_CH];
  logic [MAG_W-1:0]  ch_dmag  [NUM_CH];
  logic              ch_neg   [NUM_CH];
  logic              ch_dzero [NUM_CH];
  logic              ch_nzero [NUM_CH];
  logic              thr_le;

  logic [TIME_W-1:0] last_valid_time;
  logic [SET_W-1:0]  held_roll, held_pitch, held_throttle, held_yaw_rate;
  logic              held_mode, valid_flag, failsafe_flag;

  logic              out_valid;
  logic [SET_W-1:0]  out_roll, out_pitch, out_thr, out_yaw;
  logic              out_mode, out_frame, out_fs;

  rcpwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    assign lane_ld[g].load = (state == S_MUL) && (idx == IDX_W'(g + 1));
    assign lane_ld[g].num  = prod;
    assign lane_ld[g].den  = ch_dmag[g];

    rcpwm_div_lane u_div (
      .clk (clk),
      .rst (rst),
      .ld  (lane_ld[g]),
      .st  (lane_st[g])
    );
  end

  function automatic logic pulse_ok(input logic [PULSE_W-1:0] p);
    pulse_ok = (p >= rcpwm_pkg::PULSE_LO_US) && (p <= rcpwm_pkg::PULSE_HI_US);
  endfunction

  // Saturating signed setpoint; a zero span saturates by sign, or is 0 if nzero.
  function automatic logic [SET_W-1:0] map_signed(input rcpwm_pkg::div_status_t s,
                                                  input logic neg, input logic dzero,
                                                  input logic nzero);
    logic [SET_W-1:0] r;
    if (dzero) begin
      r = nzero ? '0 : (neg ? SAT_NEG : SAT_POS);
    end else if (neg) begin
      r = (s.ovf || s.quo[QUO_W-1]) ? SAT_NEG : SET_W'(~s.quo + 1'b1);
    end else begin
      r = (s.ovf || s.quo >= SAT_POS) ? SAT_POS : s.quo;
    end
    map_signed = r;
  endfunction

  function automatic logic [SET_W-1:0] map_throttle(input rcpwm_pkg::div_status_t s,
                                                    input logic neg, input logic dzero,
                                                    input logic le);
    logic [SET_W-1:0] r;
    if (le || (!dzero && neg)) begin
      r = '0;
    end else if (dzero || s.ovf || s.quo > rcpwm_pkg::THROTTLE_FULL) begin
      r = rcpwm_pkg::THROTTLE_FULL;
    end else begin
      r = s.quo;
    end
    map_throttle = r;
  endfunction

  // Range check, timeout, mode and operand preparation from the captured pulses.
  logic              frame_ok;
  logic              timed_out;
  logic              mode_hi;
  logic              any_busy;
  logic [TIME_W-1:0] elapsed;
  logic [US_W-1:0]   c_p     [NUM_CH];
  logic [DIFF_W-1:0] c_diff  [NUM_CH];
  logic [DIFF_W-1:0] c_den   [NUM_CH];
  logic [MAG_W-1:0]  c_mag   [NUM_CH];
  logic [MAG_W-1:0]  c_dmag  [NUM_CH];
  logic [FULL_W-1:0] c_full  [NUM_CH];
  logic [US_W-1:0]   c_ref;

  always_comb begin
    frame_ok = pulse_ok(p_roll) && pulse_ok(p_pitch) && pulse_ok(p_thr) &&
               pulse_ok(p_yaw) && pulse_ok(p_mode);
    elapsed   = now_reg - last_valid_time;
    timed_out = elapsed > TIME_W'(cfg.failsafe_timeout_ms);
    mode_hi   = p_mode >= PULSE_W'(cfg.mode_threshold_us);

    // A pulse that passed the check is at most 2100, so 12 bits hold it.
    c_p[CH_ROLL]  = p_roll[US_W-1:0];
    c_p[CH_PITCH] = p_pitch[US_W-1:0];
    c_p[CH_THR]   = p_thr[US_W-1:0];
    c_p[CH_YAW]   = p_yaw[US_W-1:0];

    c_full[CH_ROLL]  = FULL_W'(cfg.max_angle_q8);
    c_full[CH_PITCH] = FULL_W'(cfg.max_angle_q8);
    c_full[CH_THR]   = rcpwm_pkg::THROTTLE_FULL;
    c_full[CH_YAW]   = cfg.max_yaw_rate_q8;

    for (int i = 0; i < NUM_CH; i++) begin
      c_ref     = (CH_W'(i) == CH_THR) ? cfg.min_pulse_us : cfg.center_pulse_us;
      c_diff[i] = {1'b0, c_p[i]} - {1'b0, c_ref};
      c_den[i]  = {1'b0, cfg.max_pulse_us} - {1'b0, c_ref};
      c_mag[i]  = c_diff[i][DIFF_W-1] ? MAG_W'(-c_diff[i]) : c_diff[i][MAG_W-1:0];
      c_dmag[i] = c_den[i][DIFF_W-1] ? MAG_W'(-c_den[i]) : c_den[i][MAG_W-1:0];
    end

    any_busy = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      any_busy = any_busy | lane_st[i].busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      idx             <= '0;
      out_valid       <= 1'b0;
      last_valid_time <= '0;
      held_roll       <= '0;
      held_pitch      <= '0;
      held_throttle   <= '0;
      held_yaw_rate   <= '0;
      held_mode       <= 1'b0;
      valid_flag      <= 1'b0;
      failsafe_flag   <= 1'b1;
    end else begin
      // In S_DONE the output register is either reloaded or left waiting.
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (poll.valid) begin
            p_roll  <= poll.roll_pulse_us;
            p_pitch <= poll.pitch_pulse_us;
            p_thr   <= poll.throttle_pulse_us;
            p_yaw   <= poll.yaw_pulse_us;
            p_mode  <= poll.mode_pulse_us;
            now_reg <= poll.now_ms;
            state   <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (frame_ok) begin
            valid_flag      <= 1'b1;
            failsafe_flag   <= 1'b0;
            last_valid_time <= now_reg;
            held_mode       <= mode_hi;
            for (int i = 0; i < NUM_CH; i++) begin
              ch_mag[i]   <= c_mag[i];
              ch_full[i]  <= c_full[i];
              ch_dmag[i]  <= c_dmag[i];
              ch_neg[i]   <= c_diff[i][DIFF_W-1] ^ c_den[i][DIFF_W-1];
              ch_dzero[i] <= (c_den[i] == '0);
              ch_nzero[i] <= (c_mag[i] == '0) || (c_full[i] == '0);
            end
            thr_le <= c_diff[CH_THR][DIFF_W-1] || (c_diff[CH_THR] == '0);
            idx    <= '0;
            state  <= S_MUL;
          end else begin
            valid_flag <= 1'b0;
            if (timed_out) begin
              failsafe_flag <= 1'b1;
            end
            state <= S_DONE;
          end
        end

        // One product per cycle; lane k loads its product in the following cycle.
        S_MUL: begin
          if (idx < IDX_W'(NUM_CH)) begin
            prod <= PROD_W'(ch_mag[idx[CH_W-1:0]]) *
                    PROD_W'(ch_full[idx[CH_W-1:0]]);
            idx  <= idx + 1'b1;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (!any_busy) begin
            state <= S_MAP;
          end
        end

        S_MAP: begin
          held_roll <= map_signed(lane_st[CH_ROLL], ch_neg[CH_ROLL],
                                  ch_dzero[CH_ROLL], ch_nzero[CH_ROLL]);
          held_pitch <= map_signed(lane_st[CH_PITCH], ch_neg[CH_PITCH],
                                   ch_dzero[CH_PITCH], ch_nzero[CH_PITCH]);
          held_yaw_rate <= map_signed(lane_st[CH_YAW], ch_neg[CH_YAW],
                                      ch_dzero[CH_YAW], ch_nzero[CH_YAW]);
          held_throttle <= map_throttle(lane_st[CH_THR], ch_neg[CH_THR],
                                        ch_dzero[CH_THR], thr_le);
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_roll  <= held_roll;
            out_pitch <= held_pitch;
            out_thr   <= held_throttle;
            out_yaw   <= held_yaw_rate;
            out_mode  <= held_mode;
            out_frame <= valid_flag;
            out_fs    <= failsafe_flag;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign poll.ready = (state == S_IDLE);

  assign result.valid           = out_valid;
  assign result.roll_set_q8     = $signed(out_roll);
  assign result.pitch_set_q8    = $signed(out_pitch);
  assign result.throttle_q15    = out_thr;
  assign result.yaw_rate_set_q8 = $signed(out_yaw);
  assign result.land_mode       = out_mode;
  assign result.frame_valid     = out_frame;
  assign result.failsafe        = out_fs;

  `ASSERT_IMPLIES(a_valid_clears_fs, clk, rst, out_valid && out_frame, !out_fs,
                  "valid frame reported with failsafe")
  `ASSERT_IMPLIES(a_thr_range, clk, rst, out_valid, out_thr <= rcpwm_pkg::THROTTLE_FULL,
                  "throttle above full scale")
  `ASSERT_IMPLIES(a_idle_lanes, clk, rst, poll.ready, !any_busy,
                  "request taken while a divider is busy")

endmodule

`default_nettype wire
